### rtl/core/assert_macros.svh
// Assertion helpers shared by the core RTL.
// Both use clk and arst_n from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CHK_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_ALWAYS(lbl, expr, msg)
`define CHK_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/imadm_pkg.sv
package imadm_pkg;

	localparam int IdxW  = 7;
	localparam int PredW = 16;
	localparam int VolW  = 9;
	localparam int StepW = 15;

	localparam logic [IdxW-1:0] IDX_MAX    = 7'd88;
	localparam logic [VolW-1:0] VOL_RESET  = 9'd256;

	typedef enum logic {
		CMD_DECODE = 1'b0,
		CMD_LOAD   = 1'b1
	} cmd_t;

	typedef enum logic [0:0] {
		REG_VOLUME   = 1'b0,
		REG_MIX_MODE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic [7:0]              code_byte;
		logic signed [PredW-1:0] mix_in;
		logic signed [PredW-1:0] load_predictor;
		logic [IdxW-1:0]         load_index;
		logic                    load_half;
	} in_item_t;

	typedef struct packed {
		logic signed [PredW-1:0] sample_out;
		logic                    byte_done;
		logic signed [PredW-1:0] predictor;
		logic [IdxW-1:0]         step_index;
		logic                    half;
	} out_item_t;

	// decoder state plus what the scaler needs, one beat per item
	typedef struct packed {
		logic                    load;
		logic                    byte_done;
		logic signed [PredW-1:0] predictor;
		logic [IdxW-1:0]         step_index;
		logic                    half;
		logic signed [PredW-1:0] mix_in;
	} mid_t;

	localparam logic [StepW-1:0] STEP_TAB [0:88] = '{
		15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
		15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
		15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
		15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
		15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
		15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
		15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
		15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
		15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
		15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
		15'd27086, 15'd29794, 15'd32767
	};

	function automatic logic [StepW-1:0] step_lookup(input logic [IdxW-1:0] idx);
		logic [IdxW-1:0] sat;
		sat = (idx > IDX_MAX) ? IDX_MAX : idx;
		return STEP_TAB[sat];
	endfunction

	// -1 for magnitudes 0..3, then 2, 4, 6, 8
	function automatic logic signed [4:0] idx_adjust(input logic [2:0] mag);
		logic [2:0] k;
		k = {1'b0, mag[1:0]} + 3'd1;
		return mag[2] ? $signed({1'b0, k, 1'b0}) : -5'sd1;
	endfunction

endpackage

### rtl/core/imadm_decode.sv
`include "assert_macros.svh"

module imadm_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  imadm_pkg::in_item_t in_data,
	output logic               in_ready,
	output logic               mid_valid,
	output imadm_pkg::mid_t    mid_data,
	input  logic               mid_ready
);
	import imadm_pkg::*;

	logic                    valid_s1;
	in_item_t                item_s1;
	logic                    valid_s2;
	mid_t                    mid_s2;
	logic signed [PredW-1:0] pred_q;
	logic [IdxW-1:0]         index_q;
	logic                    half_q;

	logic                    free_s2;
	logic                    commit;
	logic [3:0]              nib;
	logic [StepW-1:0]        step;
	logic signed [8:0]       idx_sum;
	logic [IdxW-1:0]         idx_dec;
	logic [16:0]             diff_mag;
	logic signed [17:0]      pred_sum;
	logic signed [PredW-1:0] pred_dec;
	logic [IdxW-1:0]         idx_load;
	mid_t                    mid_next;

	assign free_s2  = !valid_s2 || mid_ready;
	assign commit   = valid_s1 && free_s2;
	assign in_ready = !valid_s1 || free_s2;

	always_comb begin
		nib     = half_q ? item_s1.code_byte[7:4] : item_s1.code_byte[3:0];
		step    = step_lookup(index_q);
		idx_sum = $signed({2'b00, index_q}) + 9'(idx_adjust(nib[2:0]));
		if (idx_sum < 0) begin
			idx_dec = '0;
		end else if (idx_sum > $signed({2'b00, IDX_MAX})) begin
			idx_dec = IDX_MAX;
		end else begin
			idx_dec = idx_sum[IdxW-1:0];
		end

		diff_mag = {5'd0, step[StepW-1:3]}
			+ (nib[2] ? {2'd0, step} : 17'd0)
			+ (nib[1] ? {3'd0, step[StepW-1:1]} : 17'd0)
			+ (nib[0] ? {4'd0, step[StepW-1:2]} : 17'd0);
		if (nib[3]) begin
			pred_sum = 18'(pred_q) - $signed({1'b0, diff_mag});
		end else begin
			pred_sum = 18'(pred_q) + $signed({1'b0, diff_mag});
		end
		if (pred_sum > 18'sd32767) begin
			pred_dec = 16'sh7fff;
		end else if (pred_sum < -18'sd32768) begin
			pred_dec = 16'sh8000;
		end else begin
			pred_dec = pred_sum[PredW-1:0];
		end

		idx_load = (item_s1.load_index > IDX_MAX) ? IDX_MAX : item_s1.load_index;

		mid_next.mix_in = item_s1.mix_in;
		if (item_s1.cmd == CMD_LOAD) begin
			mid_next.load       = 1'b1;
			mid_next.byte_done  = 1'b0;
			mid_next.predictor  = item_s1.load_predictor;
			mid_next.step_index = idx_load;
			mid_next.half       = item_s1.load_half;
		end else begin
			mid_next.load       = 1'b0;
			mid_next.byte_done  = half_q;
			mid_next.predictor  = pred_dec;
			mid_next.step_index = idx_dec;
			mid_next.half       = ~half_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pred_q   <= '0;
			index_q  <= '0;
			half_q   <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
			if (commit) begin
				pred_q  <= mid_next.predictor;
				index_q <= mid_next.step_index;
				half_q  <= mid_next.half;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (commit) begin
			mid_s2 <= mid_next;
		end
	end

	assign mid_valid = valid_s2;
	assign mid_data  = mid_s2;

	`CHK_ALWAYS(a_idx_range, index_q <= IDX_MAX, "step index out of range")
	`CHK_NEXT(a_half_flip, commit && item_s1.cmd == CMD_DECODE, half_q != $past(half_q), "half flag did not toggle on decode")
	`CHK_NEXT(a_state_report, commit, pred_q == mid_s2.predictor && index_q == mid_s2.step_index && half_q == mid_s2.half, "reported state differs from held state")
	`CHK_ALWAYS(a_done_high_nib, !(valid_s2 && mid_s2.byte_done) || (!mid_s2.load && !mid_s2.half), "byte_done without high nibble")

endmodule

### rtl/core/imadm_scale.sv
`include "assert_macros.svh"

module imadm_scale (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            mid_valid,
	input  imadm_pkg::mid_t                 mid_data,
	output logic                            mid_ready,
	input  logic [imadm_pkg::VolW-1:0]      volume,
	input  logic                            mix_mode,
	output logic                            res_valid,
	output imadm_pkg::out_item_t            res_data,
	input  logic                            res_stall
);
	import imadm_pkg::*;

	logic               res_valid_q;
	out_item_t          res_q;
	logic               take;
	logic signed [25:0] prod;
	logic [PredW-1:0]   scaled;
	out_item_t          res_next;

	assign mid_ready = !res_valid_q || !res_stall;
	assign take      = mid_valid && mid_ready;

	always_comb begin
		// |prod| < 2^24, so bits 23:8 are the floor shift truncated to 16 bits
		prod   = mid_data.predictor * $signed({1'b0, volume});
		scaled = prod[23:8];

		res_next.byte_done  = mid_data.byte_done;
		res_next.predictor  = mid_data.predictor;
		res_next.step_index = mid_data.step_index;
		res_next.half       = mid_data.half;
		if (mid_data.load) begin
			res_next.sample_out = '0;
		end else if (mix_mode) begin
			res_next.sample_out = $signed(scaled + mid_data.mix_in);
		end else begin
			res_next.sample_out = $signed(scaled);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (mid_ready) begin
			res_valid_q <= mid_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	`CHK_NEXT(a_load_zero, take && mid_data.load, res_q.sample_out == '0 && !res_q.byte_done, "load beat with nonzero sample")
	`CHK_NEXT(a_state_pass, take, res_q.predictor == $past(mid_data.predictor) && res_q.step_index == $past(mid_data.step_index), "state fields corrupted")
	`CHK_ALWAYS(a_backpressure, !(mid_valid && !mid_ready) || (res_valid_q && res_stall), "mid beat held without output stall")

endmodule

### rtl/core/ima_adpcm_decode_mix.sv
// IMA 4-bit ADPCM decoder with volume scaling and optional mix-in.
// dec channel: dec_valid/dec_stall/dec_data. A beat is taken at a clock edge
//   with dec_valid high and dec_stall low. cmd decode eats one nibble of
//   code_byte (low first, then high); cmd load restores predictor, step index
//   and half flag.
// res channel: res_valid/res_stall/res_data, one beat per input beat, in order.
//   Each beat carries the sample and the decoder state for saving.
// cfg channel: cfg_valid/cfg_ready/cfg_index/cfg_data; index 0 volume,
//   index 1 mix_mode. cfg_ready is always high; write only when idle.
// Pipeline: input register, decode stage register with the state update,
//   scale/mix output register. Throughput: one beat per cycle while
//   res_stall is low; the decoder state loop (step lookup, add, clamp)
//   is combinational between the state registers.
// A stalled result holds; the stages behind it fill, then dec_stall rises.
// Reset: predictor 0, step index 0, low nibble next, volume 256, no mix,
//   all stages empty.
module ima_adpcm_decode_mix (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        dec_valid,
	output logic                        dec_stall,
	input  imadm_pkg::in_item_t         dec_data,
	output logic                        res_valid,
	input  logic                        res_stall,
	output imadm_pkg::out_item_t        res_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  imadm_pkg::cfg_reg_t         cfg_index,
	input  logic [imadm_pkg::VolW-1:0]  cfg_data
);
	import imadm_pkg::*;

	logic [VolW-1:0] volume_q;
	logic            mix_mode_q;
	logic            dec_ready;
	logic            mid_valid;
	logic            mid_ready;
	mid_t            mid_data;

	assign cfg_ready = 1'b1;
	assign dec_stall = !dec_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q   <= VOL_RESET;
			mix_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VOLUME:   volume_q   <= cfg_data;
				REG_MIX_MODE: mix_mode_q <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	imadm_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_data   (dec_data),
		.in_ready  (dec_ready),
		.mid_valid (mid_valid),
		.mid_data  (mid_data),
		.mid_ready (mid_ready)
	);

	imadm_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (mid_valid),
		.mid_data  (mid_data),
		.mid_ready (mid_ready),
		.volume    (volume_q),
		.mix_mode  (mix_mode_q),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_stall (res_stall)
	);

endmodule
